// ===== rtl/cptb_pkg.sv =====
`default_nettype none

package cptb_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned ValW    = 16;
  localparam int unsigned MaskW   = 4;
  localparam int unsigned PhaseW  = 10;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 24;

  localparam logic [CmdW-1:0] CMD_RELOAD  = 3'd0;
  localparam logic [CmdW-1:0] CMD_CONTROL = 3'd1;
  localparam logic [CmdW-1:0] CMD_DEFER   = 3'd2;
  localparam logic [CmdW-1:0] CMD_TICK    = 3'd3;
  localparam logic [CmdW-1:0] CMD_READ    = 3'd4;

  localparam int unsigned CTL_BIT_ENABLE  = 7;
  localparam int unsigned CTL_BIT_IRQ     = 6;
  localparam int unsigned CTL_BIT_CASCADE = 2;

  localparam logic [1:0] PSC_DIV1    = 2'd0;
  localparam logic [1:0] PSC_DIV64   = 2'd1;
  localparam logic [1:0] PSC_DIV256  = 2'd2;
  localparam logic [1:0] PSC_DIV1024 = 2'd3;

  typedef struct packed {
    logic       enable;
    logic       irq;
    logic       cascade;
    logic [1:0] prescale;
  } ctl_t;

  function automatic logic phase_hit(input logic [1:0] prescale,
                                     input logic [PhaseW-1:0] phase);
    logic hit;
    hit = 1'b0;
    unique case (prescale)
      PSC_DIV1:    hit = 1'b1;
      PSC_DIV64:   hit = (phase[5:0] == 6'd0);
      PSC_DIV256:  hit = (phase[7:0] == 8'd0);
      PSC_DIV1024: hit = (phase == '0);
      default:     hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cascaded_prescaled_timer_bank_core.sv =====
// Channel | Direction | tdata fields (low bit first)                  | tuser
// in_     | slave     | timer_index[1:0], write_value[17:2], zero pad  | command[2:0]
// out_    | master    | read_data[15:0], irq_mask[19:16], ovf[23:20]   | none
//
// One transaction is accepted per cycle while the result register can drain;
// its result passes from the input register to the result register and is
// then presented on out_tdata. The timer update and the cascade chain are
// computed combinationally between the two registers.
// Reset clears all timers, the tick phase and both pipeline stages' valid flags.
// A stalled result holds the pipeline; in_tready then drops once the input
// register is full.
`default_nettype none

module cascaded_prescaled_timer_bank_core
  import cptb_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // timer_index[1:0], write_value[17:2], zeros[23:18]
  input  wire logic [InDataW-1:0]  in_tdata,
  // command[2:0]
  input  wire logic [CmdW-1:0]     in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // read_data[15:0], irq_mask[19:16], overflow_mask[23:20]
  output logic [OutDataW-1:0]      out_tdata
);

  logic                s1_valid_r;
  logic [CmdW-1:0]     s1_cmd_r;
  logic [IdxW-1:0]     s1_idx_r;
  logic [ValW-1:0]     s1_val_r;
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic                fire;

  logic [PhaseW-1:0] phase_r, phase_nxt, phase_inc;
  logic [ValW-1:0]   count_r  [NUM_TIMERS];
  logic [ValW-1:0]   count_nxt[NUM_TIMERS];
  logic [ValW-1:0]   reload_r [NUM_TIMERS];
  logic [ValW-1:0]   reload_nxt[NUM_TIMERS];
  ctl_t              ctl_r    [NUM_TIMERS];
  ctl_t              ctl_nxt  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] delay_r, delay_nxt;
  logic [NUM_TIMERS-1:0] fresh_r, fresh_nxt;
  logic [NUM_TIMERS-1:0] sel;
  logic [NUM_TIMERS-1:0] inc;
  logic [NUM_TIMERS-1:0] ovf;
  logic [NUM_TIMERS-1:0] irq;
  logic [NUM_TIMERS+MaskW-1:0] ovf_ext, irq_ext;
  logic [ValW-1:0]   rd_data;

  assign fire       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || fire;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign phase_inc  = phase_r + PhaseW'(1);

  always_comb begin
    logic carry;
    logic own;
    ctl_t c;
    carry = 1'b0;
    c     = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      sel[t] = (int'(s1_idx_r) == t);
      own = ctl_r[t].enable && !ctl_r[t].cascade && !delay_r[t] &&
            phase_hit(ctl_r[t].prescale, phase_inc);
      inc[t] = own || (carry && ctl_r[t].enable && ctl_r[t].cascade && !delay_r[t]);
      ovf[t] = inc[t] && (count_r[t] == '1);
      irq[t] = ovf[t] && ctl_r[t].irq;
      carry  = ovf[t];
    end

    phase_nxt = phase_r;
    rd_data   = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      count_nxt[t]  = count_r[t];
      reload_nxt[t] = reload_r[t];
      ctl_nxt[t]    = ctl_r[t];
      delay_nxt[t]  = delay_r[t];
      fresh_nxt[t]  = fresh_r[t];
    end

    unique case (s1_cmd_r)
      CMD_RELOAD: begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
          if (sel[t]) begin
            reload_nxt[t] = s1_val_r;
          end
        end
      end
      CMD_CONTROL: begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
          if (sel[t]) begin
            c.enable   = s1_val_r[CTL_BIT_ENABLE];
            c.irq      = s1_val_r[CTL_BIT_IRQ];
            c.cascade  = s1_val_r[CTL_BIT_CASCADE] && (t != 0);
            c.prescale = s1_val_r[1:0];
            ctl_nxt[t] = c;
            if (!ctl_r[t].enable && c.enable) begin
              count_nxt[t] = reload_r[t];
              delay_nxt[t] = 1'b0;
              fresh_nxt[t] = 1'b1;
            end
            if (!c.enable) begin
              delay_nxt[t] = 1'b0;
              fresh_nxt[t] = 1'b0;
            end
          end
        end
      end
      CMD_DEFER: begin
        delay_nxt = delay_r | fresh_r;
      end
      CMD_TICK: begin
        phase_nxt = phase_inc;
        fresh_nxt = '0;
        delay_nxt = '0;
        for (int t = 0; t < NUM_TIMERS; t++) begin
          if (inc[t]) begin
            count_nxt[t] = ovf[t] ? reload_r[t] : count_r[t] + ValW'(1);
          end
        end
      end
      CMD_READ: begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
          if (sel[t]) begin
            rd_data = rd_data | count_r[t];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign ovf_ext = (NUM_TIMERS + MaskW)'(ovf);
  assign irq_ext = (NUM_TIMERS + MaskW)'(irq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      delay_r     <= '0;
      fresh_r     <= '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        count_r[t]  <= '0;
        reload_r[t] <= '0;
        ctl_r[t]    <= '0;
      end
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        delay_r     <= delay_nxt;
        fresh_r     <= fresh_nxt;
        for (int t = 0; t < NUM_TIMERS; t++) begin
          count_r[t]  <= count_nxt[t];
          reload_r[t] <= reload_nxt[t];
          ctl_r[t]    <= ctl_nxt[t];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r <= in_tuser;
      s1_idx_r <= in_tdata[IdxW-1:0];
      s1_val_r <= in_tdata[IdxW+ValW-1:IdxW];
    end
    if (fire) begin
      if (s1_cmd_r == CMD_TICK) begin
        out_data_r <= {ovf_ext[MaskW-1:0], irq_ext[MaskW-1:0], rd_data};
      end else begin
        out_data_r <= {{(2*MaskW){1'b0}}, rd_data};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cptb_checker.sv =====
`default_nettype none

module cptb_checker
  import cptb_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_tready,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or vanished.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

  a_irq_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[19:16] & ~out_tdata[23:20]) == 4'd0)
    else $error("IRQ flagged without overflow.");

  a_tick_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[23:20] != 4'd0) |-> out_tdata[15:0] == 16'd0)
    else $error("Overflow and read data in one result.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("Input stalled while the result register is empty.");

endmodule

bind cascaded_prescaled_timer_bank_core cptb_checker u_cptb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== dv/tb_cascaded_prescaled_timer_bank_core.sv =====
`timescale 1ns / 1ps

module tb_cascaded_prescaled_timer_bank_core;
  import cptb_pkg::*;

  localparam int NT = 4;
  localparam int RANDOM_ITEMS = 1000;
  localparam int TAIL_QUIET = 150;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 48;
  localparam int DRAIN_CYCLES = 6;
  localparam realtime RUN_LIMIT = 500_000ns;

  localparam logic [CmdW-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CmdW-1:0] CMD_RSVD_LAST  = 3'd7;
  localparam logic [7:0] CTL_KEEP = (8'd1 << CTL_BIT_ENABLE) | (8'd1 << CTL_BIT_IRQ) |
                                    (8'd1 << CTL_BIT_CASCADE) | 8'd3;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] val;
  } timer_cmd_t;

  typedef struct packed {
    logic [ValW-1:0]  count;
    logic [MaskW-1:0] irq;
    logic [MaskW-1:0] ovf;
  } readout_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic [CmdW-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  cascaded_prescaled_timer_bank_core #(.NUM_TIMERS(NT)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  timer_cmd_t cmd_queue[$];
  readout_t readout_queue[$];
  int total_items = 0;
  int accepted = 0;
  int mismatches = 0;
  logic hold_active = 1'b0;

  // Shadow copy of the timer bank.
  logic [PhaseW-1:0] m_phase = '0;
  logic [ValW-1:0] m_count[NT];
  logic [ValW-1:0] m_reload[NT];
  logic [7:0] m_ctl[NT];
  logic [NT-1:0] m_delay = '0;
  logic [NT-1:0] m_fresh = '0;

  initial begin
    for (int t = 0; t < NT; t++) begin
      m_count[t] = '0;
      m_reload[t] = '0;
      m_ctl[t] = '0;
    end
  end

  function automatic bit timer_on(input int t);
    return m_ctl[t][CTL_BIT_ENABLE];
  endfunction

  function automatic bit chained(input int t);
    return (t != 0) && m_ctl[t][CTL_BIT_CASCADE];
  endfunction

  function automatic bit on_prescale_edge(input logic [1:0] sel);
    int unsigned div;
    div = (sel == PSC_DIV1) ? 1 : (1 << (2 * sel + 4));
    return (m_phase % div) == 0;
  endfunction

  function automatic void ripple_bump(input int t, inout logic [MaskW-1:0] irq,
                                      inout logic [MaskW-1:0] ovf);
    int k;
    bit done;
    k = t;
    done = 1'b0;
    while (!done) begin
      if (m_count[k] != '1) begin
        m_count[k] = m_count[k] + 1'b1;
        done = 1'b1;
      end else begin
        m_count[k] = m_reload[k];
        ovf[k] = 1'b1;
        if (m_ctl[k][CTL_BIT_IRQ]) irq[k] = 1'b1;
        if (k + 1 >= NT || !timer_on(k + 1) || !chained(k + 1) || m_delay[k + 1]) begin
          done = 1'b1;
        end else begin
          k++;
        end
      end
    end
  endfunction

  function automatic readout_t timer_bank_update(input timer_cmd_t it);
    readout_t r;
    logic [7:0] c;
    bit was;
    bit held;
    r = '0;
    case (it.cmd)
      CMD_RELOAD: m_reload[it.idx] = it.val;
      CMD_CONTROL: begin
        was = timer_on(it.idx);
        c = it.val[7:0] & CTL_KEEP;
        if (it.idx == 0) c[CTL_BIT_CASCADE] = 1'b0;
        m_ctl[it.idx] = c;
        if (!was && c[CTL_BIT_ENABLE]) begin
          m_count[it.idx] = m_reload[it.idx];
          m_delay[it.idx] = 1'b0;
          m_fresh[it.idx] = 1'b1;
        end
        if (!c[CTL_BIT_ENABLE]) begin
          m_delay[it.idx] = 1'b0;
          m_fresh[it.idx] = 1'b0;
        end
      end
      CMD_DEFER: m_delay = m_delay | m_fresh;
      CMD_TICK: begin
        m_phase = m_phase + 1'b1;
        for (int t = 0; t < NT; t++) begin
          m_fresh[t] = 1'b0;
          if (timer_on(t)) begin
            held = m_delay[t];
            m_delay[t] = 1'b0;
            if (!chained(t) && !held && on_prescale_edge(m_ctl[t][1:0])) begin
              ripple_bump(t, r.irq, r.ovf);
            end
          end
        end
      end
      CMD_READ: r.count = m_count[it.idx];
      default: ;
    endcase
    return r;
  endfunction

  function automatic void queue_cmd(input logic [CmdW-1:0] cmd, input logic [IdxW-1:0] idx,
                                    input logic [ValW-1:0] val);
    timer_cmd_t it;
    it.cmd = cmd;
    it.idx = idx;
    it.val = val;
    cmd_queue.push_back(it);
  endfunction

  function automatic logic [ValW-1:0] pick_reload();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return ValW'($urandom_range(16'hFFC0, 16'hFFFF));
    if (r < 8) return ValW'($urandom_range(0, 16'hFFFF));
    if (r < 9) return '1;
    return '0;
  endfunction

  // Sender side.
  int gap_left = 0;
  timer_cmd_t cur_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        readout_queue.push_back(timer_bank_update(cur_item));
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cur_item = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_item.cmd;
          in_tdata <= {{(InDataW - IdxW - ValW){1'b0}}, cur_item.val, cur_item.idx};
          if (!hold_active && cmd_queue.size() > TAIL_QUIET &&
              (cmd_queue.size() / 96) % 2 == 0 && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 9);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver side and result checking.
  int results_seen = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    readout_t due;
    readout_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.count = out_tdata[ValW-1:0];
        got.irq = out_tdata[ValW+MaskW-1:ValW];
        got.ovf = out_tdata[ValW+2*MaskW-1:ValW+MaskW];
        results_seen++;
        if (readout_queue.size() == 0) begin
          $error("unexpected result transaction: %h", out_tdata);
          mismatches++;
        end else begin
          due = readout_queue.pop_front();
          if (got.count !== due.count) begin
            $error("read_data: expected %h, got %h", due.count, got.count);
            mismatches++;
          end
          if (got.irq !== due.irq) begin
            $error("irq_mask: expected %h, got %h", due.irq, got.irq);
            mismatches++;
          end
          if (got.ovf !== due.ovf) begin
            $error("overflow_mask: expected %h, got %h", due.ovf, got.ovf);
            mismatches++;
          end
        end
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (results_seen < total_items - TAIL_QUIET && (results_seen / 80) % 2 == 1 &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      hold_active <= (hold_left > 0);
    end
  end

  initial begin
    int t;
    int run_len;
    int base;
    logic [ValW-1:0] raw;

    queue_cmd(CMD_READ, 2'd0, '0);
    queue_cmd(CMD_RELOAD, 2'd0, '1);
    queue_cmd(CMD_CONTROL, 2'd0, 16'hFFFC);
    queue_cmd(CMD_RELOAD, 2'd1, '1);
    queue_cmd(CMD_CONTROL, 2'd1, 16'h00C4);
    queue_cmd(CMD_TICK, 2'd0, '0);
    queue_cmd(CMD_TICK, 2'd3, '1);
    queue_cmd(CMD_RELOAD, 2'd2, '1);
    queue_cmd(CMD_CONTROL, 2'd2, 16'h0084);
    queue_cmd(CMD_DEFER, 2'd0, '0);
    queue_cmd(CMD_TICK, 2'd0, '0);
    queue_cmd(CMD_TICK, 2'd0, '0);
    queue_cmd(CMD_RELOAD, 2'd3, '0);
    queue_cmd(CMD_CONTROL, 2'd3, 16'h0083);
    queue_cmd(CMD_READ, 2'd3, '0);
    queue_cmd(CMD_CONTROL, 2'd0, '0);
    queue_cmd(CMD_TICK, 2'd0, '0);
    queue_cmd(CMD_READ, 2'd0, '0);
    queue_cmd(CMD_READ, 2'd1, '1);
    queue_cmd(CMD_RSVD_FIRST, 2'd3, '1);
    queue_cmd(CMD_RSVD_FIRST + 1'b1, 2'd2, '1);
    queue_cmd(CMD_RSVD_LAST, 2'd1, '1);
    queue_cmd(CMD_CONTROL, 2'd1, 16'h0041);
    queue_cmd(CMD_READ, 2'd2, '1);
    queue_cmd(CMD_CONTROL, 2'd3, '0);

    base = cmd_queue.size();
    while (cmd_queue.size() - base < RANDOM_ITEMS) begin
      t = $urandom_range(0, 99);
      if (t < 8) begin
        queue_cmd(CmdW'($urandom_range(0, 7)), IdxW'($urandom_range(0, 3)),
                  ValW'($urandom_range(0, 16'hFFFF)));
      end else if (t < 14) begin
        queue_cmd(CMD_CONTROL, IdxW'($urandom_range(0, 3)), ValW'($urandom_range(0, 16'hFFFF)));
        queue_cmd(CMD_DEFER, IdxW'($urandom_range(0, 3)), ValW'($urandom_range(0, 16'hFFFF)));
        queue_cmd(CMD_READ, IdxW'($urandom_range(0, 3)), ValW'($urandom_range(0, 16'hFFFF)));
      end else begin
        t = $urandom_range(0, NT - 1);
        queue_cmd(CMD_RELOAD, IdxW'(t), pick_reload());
        raw = ValW'($urandom_range(0, 16'hFFFF));
        raw[CTL_BIT_ENABLE] = ($urandom_range(0, 9) < 8);
        raw[1:0] = ($urandom_range(0, 9) < 6) ? PSC_DIV1 : 2'($urandom_range(0, 3));
        queue_cmd(CMD_CONTROL, IdxW'(t), raw);
        if ($urandom_range(0, 1)) queue_cmd(CMD_DEFER, IdxW'($urandom_range(0, 3)), '0);
        run_len = $urandom_range(5, 60);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_cmd(CMD_READ, IdxW'($urandom_range(0, 3)), ValW'($urandom_range(0, 16'hFFFF)));
          end else begin
            queue_cmd(CMD_TICK, IdxW'($urandom_range(0, 3)), ValW'($urandom_range(0, 16'hFFFF)));
          end
        end
      end
    end
    total_items = cmd_queue.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < total_items) @(posedge clk);
    while (readout_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (readout_queue.size() != 0) begin
      $error("results still outstanding: %0d", readout_queue.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_cascaded_prescaled_timer_bank_core: clean");
    end else begin
      $display("tb_cascaded_prescaled_timer_bank_core: errors");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb_cascaded_prescaled_timer_bank_core: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cptb_pkg.sv
rtl/cascaded_prescaled_timer_bank_core.sv
rtl/cptb_checker.sv
dv/tb_cascaded_prescaled_timer_bank_core.sv
